>>> sv/frac_pkg.sv
// Shared types and constants for the four-register accumulator processor.
package frac_pkg;

  localparam int MemDepth = 256;
  localparam int WordBits = 32;
  localparam int NumRegs  = 4;

  localparam logic [1:0] CmdLoad = 2'd0;
  localparam logic [1:0] CmdSetPc = 2'd1;
  localparam logic [1:0] CmdExec = 2'd2;

  localparam logic [1:0] FaultNone = 2'd0;
  localparam logic [1:0] FaultOpcode = 2'd1;
  localparam logic [1:0] FaultReg = 2'd2;
  localparam logic [1:0] FaultDivZero = 2'd3;

  localparam int OpNop = 0;
  localparam int OpHalt = 1;
  localparam int OpMovRR = 2;
  localparam int OpMovRM = 3;
  localparam int OpMovMR = 4;
  localparam int OpMovRI = 5;
  localparam int OpMovMI = 6;
  localparam int OpAdd = 7;
  localparam int OpSub = 8;
  localparam int OpCmp = 9;
  localparam int OpJmp = 10;
  localparam int OpJz = 11;
  localparam int OpJg = 12;
  localparam int OpJl = 13;
  localparam int OpOut = 14;
  localparam int OpInc = 15;
  localparam int OpDec = 16;
  localparam int OpMul = 17;
  localparam int OpDiv = 18;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] address;
    logic [31:0] data;
  } cmd_t;

endpackage

>>> sv/frac_front.sv
// Input stage and two-entry command queue of the processor.
module frac_front
  import frac_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  cmd_t       in_cmd_i,
  output logic       q_valid_o,
  input  logic       q_ready_i,
  output cmd_t       q_cmd_o
);

  cmd_t       buf_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o = cnt_q != 2'd2;
  assign push = in_valid_i && in_ready_o;
  assign pop = q_valid_o && q_ready_i;
  assign q_valid_o = cnt_q != 2'd0;
  assign q_cmd_o = buf_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_q] <= in_cmd_i;
  end

endmodule

>>> sv/frac_div.sv
// Iterative signed divider, one quotient bit per cycle.
module frac_div #(
  parameter int W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  output logic         done_o,
  output logic [W-1:0] q_o
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem_q, quo_q, div_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, neg_q;
  logic [W:0]    trial;

  assign trial = {rem_q, quo_q[W-1]} - {1'b0, div_q};
  assign q_o = neg_q ? (~quo_q + 1'b1) : quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= CW'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= a_i[W-1] ? (~a_i + 1'b1) : a_i;
      div_q <= b_i[W-1] ? (~b_i + 1'b1) : b_i;
      neg_q <= a_i[W-1] ^ b_i[W-1];
    end else if (busy_q) begin
      if (!trial[W]) begin
        rem_q <= trial[W-1:0];
        quo_q <= {quo_q[W-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[W-2:0], quo_q[W-1]};
        quo_q <= {quo_q[W-2:0], 1'b0};
      end
    end
  end

endmodule

>>> sv/frac_back.sv
// Execution sequencer with register file and unified memory.
module frac_back
  import frac_pkg::*;
#(
  parameter int MEM_DEPTH = MemDepth,
  parameter int WORD_BITS = WordBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  output logic        q_ready_o,
  input  cmd_t        q_cmd_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  program_counter_o,
  output logic        halted_o,
  output logic        out_valid_flag_o,
  output logic [1:0]  out_register_o,
  output logic [31:0] out_value_o,
  output logic [1:0]  fault_o
);

  localparam int AW = $clog2(MEM_DEPTH);
  localparam int W = WORD_BITS;

  typedef enum logic [3:0] {
    StIdle, StRdOp, StRdA, StRdB, StDec, StRdM, StWrM, StMul, StDiv, StDivW, StDone
  } state_e;

  state_e        state_q;
  logic [W-1:0]  mem_q [MEM_DEPTH];
  logic [W-1:0]  rdata_q;
  logic [AW-1:0] raddr;
  logic          ren;
  logic [W-1:0]  regs_q [NumRegs];
  logic [W-1:0]  cmp_q;
  logic [AW-1:0] pc_q;
  logic          stop_q;
  logic [W-1:0]  op_q, a_q, b_q, prod_q;
  logic [1:0]    ra, rb;
  logic          bad_a, bad_b, two_regs, first_reg;
  logic          div_start, div_done;
  logic [W-1:0]  div_q;
  logic [AW-1:0] rel;

  assign ra = a_q[1:0];
  assign rb = b_q[1:0];
  assign bad_a = a_q >= W'(NumRegs);
  assign bad_b = b_q >= W'(NumRegs);
  assign two_regs = op_q == W'(OpMovRR) || op_q == W'(OpAdd) || op_q == W'(OpSub) ||
                    op_q == W'(OpCmp) || op_q == W'(OpMul) || op_q == W'(OpDiv);
  assign first_reg = two_regs || op_q == W'(OpMovRM) || op_q == W'(OpMovRI) ||
                     op_q == W'(OpInc) || op_q == W'(OpDec);
  assign q_ready_o = state_q == StIdle && !out_valid_o;
  assign div_start = state_q == StDec && op_q == W'(OpDiv) && !(first_reg && bad_a) &&
                     !bad_b && regs_q[rb] != '0;
  // Relative target: p + 1 + offset, wrapping at the power-of-two depth.
  assign rel = pc_q + AW'(1) + a_q[AW-1:0];

  always_comb begin
    ren = 1'b0;
    raddr = pc_q;
    case (state_q)
      StIdle: begin
        ren = q_valid_i && q_ready_o && q_cmd_i.command == CmdExec && !stop_q;
        raddr = pc_q;
      end
      StRdOp: begin
        ren = 1'b1;
        raddr = pc_q + AW'(1);
      end
      StRdA: begin
        ren = 1'b1;
        raddr = pc_q + AW'(2);
      end
      StDec: begin
        ren = op_q == W'(OpMovRM);
        raddr = b_q[AW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ren) rdata_q <= mem_q[raddr];
    if (state_q == StIdle && q_valid_i && q_ready_o && q_cmd_i.command == CmdLoad) begin
      mem_q[q_cmd_i.address[AW-1:0]] <= W'(q_cmd_i.data);
    end else if (state_q == StWrM) begin
      mem_q[a_q[AW-1:0]] <= (op_q == W'(OpMovMR)) ? regs_q[rb] : b_q;
    end
    if (state_q == StDec) prod_q <= regs_q[ra] * regs_q[rb];
  end

  frac_div #(.W(W)) u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start),
    .a_i(regs_q[ra]), .b_i(regs_q[rb]), .done_o(div_done), .q_o(div_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pc_q <= '0;
      stop_q <= 1'b0;
      cmp_q <= '0;
      for (int i = 0; i < NumRegs; i++) regs_q[i] <= '0;
      out_valid_o <= 1'b0;
      out_valid_flag_o <= 1'b0;
      out_register_o <= '0;
      out_value_o <= '0;
      fault_o <= FaultNone;
      op_q <= '0;
      a_q <= '0;
      b_q <= '0;
    end else begin
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      case (state_q)
        StIdle: begin
          if (q_valid_i && q_ready_o) begin
            out_valid_flag_o <= 1'b0;
            out_register_o <= '0;
            out_value_o <= '0;
            fault_o <= FaultNone;
            if (q_cmd_i.command == CmdSetPc) begin
              pc_q <= q_cmd_i.address[AW-1:0];
              stop_q <= 1'b0;
            end
            if (q_cmd_i.command == CmdExec && !stop_q) state_q <= StRdOp;
            else state_q <= StDone;
          end
        end
        StRdOp: begin
          op_q <= rdata_q;
          state_q <= StRdA;
        end
        StRdA: begin
          a_q <= rdata_q;
          state_q <= StRdB;
        end
        StRdB: begin
          b_q <= rdata_q;
          state_q <= StDec;
        end
        StDec: begin
          state_q <= StRdM;
        end
        StRdM: begin
          state_q <= StDone;
          if (op_q > W'(OpDiv)) begin
            fault_o <= FaultOpcode;
            stop_q <= 1'b1;
          end else if ((first_reg && bad_a) ||
                       ((two_regs || op_q == W'(OpMovMR)) && bad_b)) begin
            fault_o <= FaultReg;
            stop_q <= 1'b1;
          end else begin
            case (op_q[4:0])
              5'(OpNop): pc_q <= pc_q + AW'(1);
              5'(OpHalt): stop_q <= 1'b1;
              5'(OpMovRR): begin
                regs_q[ra] <= regs_q[rb];
                pc_q <= pc_q + AW'(3);
              end
              5'(OpMovRM): begin
                regs_q[ra] <= rdata_q;
                pc_q <= pc_q + AW'(3);
              end
              5'(OpMovMR), 5'(OpMovMI): state_q <= StWrM;
              5'(OpMovRI): begin
                regs_q[ra] <= b_q;
                pc_q <= pc_q + AW'(3);
              end
              5'(OpAdd): begin
                regs_q[ra] <= regs_q[ra] + regs_q[rb];
                pc_q <= pc_q + AW'(3);
              end
              5'(OpSub): begin
                regs_q[ra] <= regs_q[ra] - regs_q[rb];
                pc_q <= pc_q + AW'(3);
              end
              5'(OpCmp): begin
                cmp_q <= regs_q[ra] - regs_q[rb];
                pc_q <= pc_q + AW'(3);
              end
              5'(OpJmp): pc_q <= a_q[AW-1:0];
              5'(OpJz): pc_q <= (cmp_q == '0) ? rel : pc_q + AW'(2);
              5'(OpJg): pc_q <= (cmp_q != '0 && !cmp_q[W-1]) ? rel : pc_q + AW'(2);
              5'(OpJl): pc_q <= cmp_q[W-1] ? rel : pc_q + AW'(2);
              5'(OpOut): begin
                if (!bad_a) begin
                  out_valid_flag_o <= 1'b1;
                  out_register_o <= ra;
                  out_value_o <= 32'(regs_q[ra]);
                end
                pc_q <= pc_q + AW'(2);
              end
              5'(OpInc): begin
                regs_q[ra] <= regs_q[ra] + 1'b1;
                pc_q <= pc_q + AW'(2);
              end
              5'(OpDec): begin
                regs_q[ra] <= regs_q[ra] - 1'b1;
                pc_q <= pc_q + AW'(2);
              end
              5'(OpMul): state_q <= StMul;
              default: begin
                if (regs_q[rb] == '0) begin
                  fault_o <= FaultDivZero;
                  stop_q <= 1'b1;
                end else begin
                  state_q <= StDiv;
                end
              end
            endcase
          end
        end
        StWrM: begin
          pc_q <= pc_q + AW'(3);
          state_q <= StDone;
        end
        StMul: begin
          regs_q[ra] <= prod_q;
          pc_q <= pc_q + AW'(3);
          state_q <= StDone;
        end
        StDiv: state_q <= StDivW;
        StDivW: begin
          if (div_done) begin
            regs_q[ra] <= div_q;
            pc_q <= pc_q + AW'(3);
            state_q <= StDone;
          end
        end
        StDone: begin
          out_valid_o <= 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign program_counter_o = 8'(pc_q);
  assign halted_o = stop_q;

endmodule

>>> sv/four_register_accumulator_cpu_step.sv
// Load and set-PC go from acceptance through the done state to the result beat.
// An executed instruction reads opcode and operands from the single-port memory in turn, then
// decodes, executes; MUL and stores add StMul or StWrM, DIV waits on the bit-serial divider.
// One item at a time; a two-beat command queue takes input while the sequencer works.
// Reset clears registers, compare result, PC and the stop flag; memory is not cleared.
module four_register_accumulator_cpu_step
  import frac_pkg::*;
#(
  parameter int MEM_DEPTH = MemDepth,
  parameter int WORD_BITS = WordBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [7:0]  address_i,
  input  logic [31:0] data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  program_counter_o,
  output logic        halted_o,
  output logic        out_valid_flag_o,
  output logic [1:0]  out_register_o,
  output logic [31:0] out_value_o,
  output logic [1:0]  fault_o
);

  cmd_t in_cmd, q_cmd;
  logic q_valid, q_ready;

  assign in_cmd = '{command: command_i, address: address_i, data: data_i};

  frac_front u_front (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .in_cmd_i(in_cmd), .q_valid_o(q_valid), .q_ready_i(q_ready), .q_cmd_o(q_cmd)
  );

  frac_back #(.MEM_DEPTH(MEM_DEPTH), .WORD_BITS(WORD_BITS)) u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .q_valid_i(q_valid), .q_ready_o(q_ready),
    .q_cmd_i(q_cmd), .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .program_counter_o(program_counter_o), .halted_o(halted_o),
    .out_valid_flag_o(out_valid_flag_o), .out_register_o(out_register_o),
    .out_value_o(out_value_o), .fault_o(fault_o)
  );

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the four-register accumulator processor step block.
`timescale 1ns / 100ps

module testbench;
  import frac_pkg::*;

  typedef struct {
    logic [1:0]  command;
    logic [7:0]  address;
    logic [31:0] data;
  } beat_t;

  typedef struct {
    logic [7:0]  pc;
    logic        halted;
    logic        shown;
    logic [1:0]  shown_reg;
    logic [31:0] shown_value;
    logic [1:0]  fault;
  } status_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  command_i = CmdLoad;
  logic [7:0]  address_i = '0;
  logic [31:0] data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  program_counter_o;
  logic        halted_o;
  logic        out_valid_flag_o;
  logic [1:0]  out_register_o;
  logic [31:0] out_value_o;
  logic [1:0]  fault_o;

  four_register_accumulator_cpu_step dut (.*);

  always #6 clk_i = ~clk_i;

  // Processor state as seen by the generator.
  logic [31:0] cpu_regs [NumRegs];
  logic [31:0] cpu_cmp;
  logic [7:0]  cpu_pc;
  logic [31:0] cpu_mem [MemDepth];
  logic        cpu_stopped;

  beat_t   pending_beats[$];
  status_t expected_status[$];
  int      items_made, execs_made, faults_made, outs_made;
  int      mismatches, results_seen, beats_sent;
  int      send_gap, recv_stall, recv_hold;
  bit      hold_done;

  function automatic logic [31:0] signed_quotient(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  function automatic logic [1:0] step_instruction(ref status_t st);
    logic [31:0] op, a, b;
    logic [7:0]  p;
    bit          two_regs, first_reg;
    p = cpu_pc;
    op = cpu_mem[p];
    a = cpu_mem[8'(p + 8'd1)];
    b = cpu_mem[8'(p + 8'd2)];
    two_regs = op == OpMovRR || op == OpAdd || op == OpSub || op == OpCmp ||
               op == OpMul || op == OpDiv;
    first_reg = two_regs || op == OpMovRM || op == OpMovRI || op == OpInc || op == OpDec;
    if (op > OpDiv) return FaultOpcode;
    if ((first_reg && a >= NumRegs) || ((two_regs || op == OpMovMR) && b >= NumRegs))
      return FaultReg;
    case (op)
      OpNop: p = p + 8'd1;
      OpHalt: cpu_stopped = 1'b1;
      OpMovRR: begin cpu_regs[a[1:0]] = cpu_regs[b[1:0]]; p = p + 8'd3; end
      OpMovRM: begin cpu_regs[a[1:0]] = cpu_mem[b[7:0]]; p = p + 8'd3; end
      OpMovMR: begin cpu_mem[a[7:0]] = cpu_regs[b[1:0]]; p = p + 8'd3; end
      OpMovRI: begin cpu_regs[a[1:0]] = b; p = p + 8'd3; end
      OpMovMI: begin cpu_mem[a[7:0]] = b; p = p + 8'd3; end
      OpAdd: begin cpu_regs[a[1:0]] = cpu_regs[a[1:0]] + cpu_regs[b[1:0]]; p = p + 8'd3; end
      OpSub: begin cpu_regs[a[1:0]] = cpu_regs[a[1:0]] - cpu_regs[b[1:0]]; p = p + 8'd3; end
      OpCmp: begin cpu_cmp = cpu_regs[a[1:0]] - cpu_regs[b[1:0]]; p = p + 8'd3; end
      OpJmp: p = a[7:0];
      OpJz: p = (cpu_cmp == 0) ? p + 8'd1 + a[7:0] : p + 8'd2;
      OpJg: p = (cpu_cmp != 0 && !cpu_cmp[31]) ? p + 8'd1 + a[7:0] : p + 8'd2;
      OpJl: p = cpu_cmp[31] ? p + 8'd1 + a[7:0] : p + 8'd2;
      OpOut: begin
        if (a < NumRegs) begin
          st.shown = 1'b1;
          st.shown_reg = a[1:0];
          st.shown_value = cpu_regs[a[1:0]];
        end
        p = p + 8'd2;
      end
      OpInc: begin cpu_regs[a[1:0]] = cpu_regs[a[1:0]] + 32'd1; p = p + 8'd2; end
      OpDec: begin cpu_regs[a[1:0]] = cpu_regs[a[1:0]] - 32'd1; p = p + 8'd2; end
      OpMul: begin cpu_regs[a[1:0]] = cpu_regs[a[1:0]] * cpu_regs[b[1:0]]; p = p + 8'd3; end
      default: begin
        if (cpu_regs[b[1:0]] == 0) return FaultDivZero;
        cpu_regs[a[1:0]] = signed_quotient(cpu_regs[a[1:0]], cpu_regs[b[1:0]]);
        p = p + 8'd3;
      end
    endcase
    cpu_pc = p;
    return FaultNone;
  endfunction

  function automatic void issue(logic [1:0] cmd, logic [7:0] addr, logic [31:0] data);
    status_t st;
    beat_t   bt;
    st = '{pc: 8'd0, halted: 1'b0, shown: 1'b0, shown_reg: 2'd0, shown_value: 32'd0,
           fault: FaultNone};
    if (cmd == CmdLoad) begin
      cpu_mem[addr] = data;
    end else if (cmd == CmdSetPc) begin
      cpu_pc = addr;
      cpu_stopped = 1'b0;
    end else if (cmd == CmdExec && !cpu_stopped) begin
      st.fault = step_instruction(st);
      if (st.fault != FaultNone) cpu_stopped = 1'b1;
      execs_made++;
    end
    st.pc = cpu_pc;
    st.halted = cpu_stopped;
    if (st.fault != FaultNone) faults_made++;
    if (st.shown) outs_made++;
    bt = '{command: cmd, address: addr, data: data};
    pending_beats.push_back(bt);
    expected_status.push_back(st);
    items_made++;
  endfunction

  function automatic void run_steps(int n);
    for (int i = 0; i < n; i++) issue(CmdExec, 8'd0, $urandom);
  endfunction

  function automatic logic [31:0] any_reg();
    return ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 3));
  endfunction

  function automatic logic [31:0] any_word();
    case ($urandom_range(0, 3))
      0: return 32'($urandom_range(0, 255));
      1: return -32'($urandom_range(1, 8));
      2: return 32'($urandom_range(0, 8));
      default: return $urandom;
    endcase
  endfunction

  // Writes one random instruction at addr and returns its length in words.
  function automatic int place_instruction(logic [7:0] addr);
    logic [31:0] op;
    int          len;
    op = ($urandom_range(0, 14) == 0) ? $urandom : 32'($urandom_range(OpNop, OpDiv));
    if (op == OpHalt && $urandom_range(0, 2) != 0) op = OpNop;
    issue(CmdLoad, addr, op);
    len = 1;
    if (op >= OpMovRR && op <= OpDiv) begin
      case (op)
        OpMovMR, OpMovMI, OpJmp, OpJz, OpJg, OpJl: issue(CmdLoad, addr + 8'd1, any_word());
        default: issue(CmdLoad, addr + 8'd1, any_reg());
      endcase
      len = 2;
      if (op <= OpCmp || op >= OpMul) begin
        case (op)
          OpMovRM, OpMovRI, OpMovMI: issue(CmdLoad, addr + 8'd2, any_word());
          default: issue(CmdLoad, addr + 8'd2, any_reg());
        endcase
        len = 3;
      end
    end
    return len;
  endfunction

  function automatic void put_program(logic [7:0] base, logic [31:0] words[]);
    foreach (words[i]) issue(CmdLoad, base + 8'(i), words[i]);
  endfunction

  initial begin
    logic [7:0] base;
    cpu_regs = '{default: 32'd0};
    cpu_cmp = '0;
    cpu_pc = '0;
    cpu_stopped = 1'b0;
    // Every memory word is written first so that no fetch reads an unwritten word.
    for (int i = 0; i < MemDepth; i++) issue(CmdLoad, 8'(i), $urandom);
    issue(CmdLoad, 8'd255, 32'h7fffffff);
    issue(CmdLoad, 8'd254, 32'h80000000);
    put_program(8'd16, '{OpMovRI, 0, 32'h80000000, OpMovRI, 1, 32'hffffffff, OpDiv, 0, 1,
                         OpOut, 0, OpOut, 7, OpCmp, 0, 1, OpJl, 3});
    issue(CmdSetPc, 8'd16, 32'd0);
    run_steps(7);
    put_program(8'd40, '{OpMovRI, 2, 0, OpDiv, 0, 2});
    issue(CmdSetPc, 8'd40, 32'd0);
    run_steps(3);
    put_program(8'd60, '{32'hfffffffb});
    issue(CmdSetPc, 8'd60, 32'd0);
    run_steps(2);
    issue(2'd3, 8'd255, 32'hffffffff);
    put_program(8'd70, '{OpMovRR, 9, 0, OpHalt});
    issue(CmdSetPc, 8'd70, 32'd0);
    run_steps(1);
    issue(CmdSetPc, 8'd73, 32'd0);
    run_steps(2);
    while (items_made < 1450) begin
      if ($urandom_range(0, 4) != 0) begin
        base = 8'($urandom);
        for (int i = 0, n = $urandom_range(1, 8); i < n; i++)
          base = base + 8'(place_instruction(base));
        issue(CmdSetPc, base - 8'($urandom_range(0, 20)), $urandom);
        run_steps($urandom_range(1, 12));
      end else begin
        case ($urandom_range(0, 3))
          0: issue(CmdLoad, 8'($urandom), $urandom);
          1: issue(CmdSetPc, 8'($urandom), $urandom);
          2: issue(CmdExec, 8'($urandom), $urandom);
          default: issue(2'd3, 8'($urandom), $urandom);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      beat_t bt;
      if (in_valid_i) beats_sent++;
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_beats.size() > 150 && $urandom_range(0, 19) == 0) begin
        send_gap = $urandom_range(0, 18);
        in_valid_i <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        bt = pending_beats.pop_front();
        in_valid_i <= 1'b1;
        command_i <= bt.command;
        address_i <= bt.address;
        data_i <= bt.data;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        status_t st;
        results_seen++;
        if (expected_status.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result beat, pc %0d", program_counter_o);
        end else begin
          st = expected_status.pop_front();
          if (program_counter_o !== st.pc || halted_o !== st.halted ||
              out_valid_flag_o !== st.shown || out_register_o !== st.shown_reg ||
              out_value_o !== st.shown_value || fault_o !== st.fault) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Result %0d: expected pc %0d halt %b out %b/%0d/%h fault %0d, got %0d %b %b/%0d/%h %0d",
                       results_seen, st.pc, st.halted, st.shown, st.shown_reg, st.shown_value,
                       st.fault, program_counter_o, halted_o, out_valid_flag_o, out_register_o,
                       out_value_o, fault_o);
          end
        end
      end
      if (!hold_done && results_seen >= 500) begin
        hold_done = 1'b1;
        recv_hold = 400;
      end
      if (recv_hold > 0) begin
        recv_hold--;
        out_ready_i <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        out_ready_i <= 1'b0;
      end else if (pending_beats.size() > 150 && $urandom_range(0, 14) == 0) begin
        recv_stall = $urandom_range(0, 18);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (items_made > 0);
    while (pending_beats.size() > 0 || in_valid_i || expected_status.size() > 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("Sent %0d beats: %0d instruction steps, %0d faults, %0d OUT values; %0d results checked.",
             beats_sent, execs_made, faults_made, outs_made, results_seen);
    if (mismatches == 0) begin
      $display("four_register_accumulator_cpu_step verification clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("four_register_accumulator_cpu_step verification failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timed out with %0d results outstanding.", expected_status.size());
    $display("four_register_accumulator_cpu_step verification failed");
    $finish;
  end

endmodule
